[design/ptmr_pkg.sv]
// ----------------------------------------------------------------------------
// Periodic timer package
// Command, status and sequencer codes shared by the timer core and its
// iterative multiply/divide unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ptmr_pkg;

  localparam int unsigned TimeW = 64;
  localparam int unsigned RetryW = 32;

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_STOP   = 2'd1,
    ACT_IVAL   = 2'd2,
    ACT_SAMPLE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_ACTIVE    = 2'd2,
    ST_SUSPENDED = 2'd3
  } status_e;

  typedef enum logic {
    CFG_MIN_INTERVAL = 1'b0,
    CFG_LATE_RETRY   = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    MD_MUL = 1'b0,
    MD_DIV = 1'b1
  } md_op_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_EXEC,
    SEQ_WAITC,
    SEQ_MUL,
    SEQ_CHK,
    SEQ_DIV,
    SEQ_CATCH,
    SEQ_DONE
  } seq_e;

  typedef struct packed {
    logic   start;
    md_op_e op;
  } md_req_t;

endpackage

`default_nettype wire

[design/periodic_timer_with_catchup_core.sv]
// ----------------------------------------------------------------------------
// Periodic timer with catch-up
// Start/stop/interval commands and time samples; periodic fire times are
// computed with a shared iterative multiply/divide unit.
// ----------------------------------------------------------------------------
// Sequencing: start, stop, change interval and non-firing samples need no
//   arithmetic; a periodic firing waits for a multiply, a late periodic
//   firing for a multiply and then a divide.
// Throughput: one word at a time; the input stalls until the sequencer idles.
// Reset: asynchronous, active low; timer suspended, config at defaults.
`default_nettype none

module periodic_timer_with_catchup_core #(
  parameter int unsigned CATCHUP_LIMIT = 60
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [63:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [63:0] now_ns_i,
  input  wire logic [63:0] first_delay_i,
  input  wire logic [63:0] new_interval_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic             fire_o,
  output logic [63:0]      fire_tick_o,
  output logic [63:0]      wait_ns_o
);
  import ptmr_pkg::*;

  seq_e              state_q, state_d;
  logic [63:0]       min_q;
  logic [RetryW-1:0] retry_q;

  logic        running_q, running_d;
  logic [63:0] start_q, start_d;
  logic [63:0] next_q, next_d;
  logic [63:0] tick_q, tick_d;
  logic [63:0] period_q, period_d;

  action_e     act_q, act_d;
  logic [63:0] now_q, now_d;
  logic [63:0] first_q, first_d;
  logic [63:0] ival_q, ival_d;
  logic [63:0] nxt_q, nxt_d;

  status_e     res_status_q, res_status_d;
  logic        res_fire_q, res_fire_d;
  logic [63:0] res_tick_q, res_tick_d;
  logic [63:0] res_wait_q, res_wait_d;

  logic        out_valid_q, out_valid_d;
  status_e     out_status_q, out_status_d;
  logic        out_fire_q, out_fire_d;
  logic [63:0] out_tick_q, out_tick_d;
  logic [63:0] out_wait_q, out_wait_d;

  md_req_t     md_req;
  logic [63:0] md_a, md_b, md_res;
  logic        md_done;
  logic [63:0] tick_inc;
  logic [63:0] behind;

  ptmr_muldiv u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (md_req),
    .a_i      (md_a),
    .b_i      (md_b),
    .done_o   (md_done),
    .result_o (md_res)
  );

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= 64'd100000000;
      retry_q <= RetryW'(1000000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_INTERVAL: min_q   <= cfg_wdata_i;
        CFG_LATE_RETRY:   retry_q <= cfg_wdata_i[RetryW-1:0];
        default:          ;
      endcase
    end
  end

  assign tick_inc = tick_q + 64'd1;
  assign behind   = nxt_q - tick_q;

  always_comb begin
    state_d      = state_q;
    running_d    = running_q;
    start_d      = start_q;
    next_d       = next_q;
    tick_d       = tick_q;
    period_d     = period_q;
    act_d        = act_q;
    now_d        = now_q;
    first_d      = first_q;
    ival_d       = ival_q;
    nxt_d        = nxt_q;
    res_status_d = res_status_q;
    res_fire_d   = res_fire_q;
    res_tick_d   = res_tick_q;
    res_wait_d   = res_wait_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_fire_d   = out_fire_q;
    out_tick_d   = out_tick_q;
    out_wait_d   = out_wait_q;
    md_req.start = 1'b0;
    md_req.op    = MD_MUL;
    md_a         = tick_inc;
    md_b         = period_q;

    unique case (state_q)
      SEQ_IDLE: begin
        if (in_valid_i) begin
          act_d        = action_e'(action_i);
          now_d        = now_ns_i;
          first_d      = first_delay_i;
          ival_d       = new_interval_i;
          res_status_d = ST_OK;
          res_fire_d   = 1'b0;
          res_tick_d   = '0;
          res_wait_d   = '0;
          state_d      = SEQ_EXEC;
        end
      end
      SEQ_EXEC: begin
        state_d = SEQ_WAITC;
        unique case (act_q)
          ACT_START: begin
            if (first_q != 64'd0 && first_q < min_q) begin
              res_status_d = ST_RANGE;
            end else if (running_q) begin
              res_status_d = ST_ACTIVE;
            end else begin
              tick_d    = '0;
              start_d   = now_q + first_q;
              next_d    = now_q + first_q;
              running_d = 1'b1;
            end
          end
          ACT_STOP: begin
            if (!running_q) begin
              res_status_d = ST_SUSPENDED;
            end else begin
              running_d = 1'b0;
            end
            state_d = SEQ_DONE;
          end
          ACT_IVAL: begin
            if (ival_q != 64'd0 && ival_q < min_q) begin
              res_status_d = ST_RANGE;
            end else begin
              period_d = ival_q;
              if (running_q) begin
                tick_d  = '0;
                start_d = now_q;
                next_d  = now_q;
              end
            end
          end
          ACT_SAMPLE: begin
            state_d = SEQ_DONE;
            if (running_q) begin
              if (now_q >= next_q) begin
                tick_d     = tick_inc;
                res_fire_d = 1'b1;
                res_tick_d = tick_inc;
                if (period_q == 64'd0) begin
                  running_d = 1'b0;
                end else begin
                  md_req.start = 1'b1;
                  md_req.op    = MD_MUL;
                  state_d      = SEQ_MUL;
                end
              end else begin
                res_wait_d = next_q - now_q;
              end
            end
          end
          default: ;
        endcase
      end
      SEQ_WAITC: begin
        if (running_q && next_q > now_q) begin
          res_wait_d = next_q - now_q;
        end
        state_d = SEQ_DONE;
      end
      SEQ_MUL: begin
        if (md_done) begin
          nxt_d   = start_q + md_res;
          state_d = SEQ_CHK;
        end
      end
      SEQ_CHK: begin
        if (nxt_q > now_q) begin
          res_wait_d = nxt_q - now_q;
          next_d     = nxt_q;
          state_d    = SEQ_DONE;
        end else begin
          md_req.start = 1'b1;
          md_req.op    = MD_DIV;
          md_a         = now_q - start_q;
          md_b         = period_q;
          state_d      = SEQ_DIV;
        end
      end
      SEQ_DIV: begin
        if (md_done) begin
          nxt_d   = md_res;
          state_d = SEQ_CATCH;
        end
      end
      SEQ_CATCH: begin
        // nxt_q holds the number of whole periods elapsed since the start
        if (behind > 64'(CATCHUP_LIMIT)) begin
          tick_d = nxt_q - 64'd1;
        end
        res_wait_d = {{(64-RetryW){1'b0}}, retry_q};
        next_d     = now_q + {{(64-RetryW){1'b0}}, retry_q};
        state_d    = SEQ_DONE;
      end
      SEQ_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_fire_d   = res_fire_q;
          out_tick_d   = res_tick_q;
          out_wait_d   = res_wait_q;
          state_d      = SEQ_IDLE;
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEQ_IDLE;
      running_q   <= 1'b0;
      start_q     <= '0;
      next_q      <= '0;
      tick_q      <= '0;
      period_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      start_q     <= start_d;
      next_q      <= next_d;
      tick_q      <= tick_d;
      period_q    <= period_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    now_q        <= now_d;
    first_q      <= first_d;
    ival_q       <= ival_d;
    nxt_q        <= nxt_d;
    res_status_q <= res_status_d;
    res_fire_q   <= res_fire_d;
    res_tick_q   <= res_tick_d;
    res_wait_q   <= res_wait_d;
    out_status_q <= out_status_d;
    out_fire_q   <= out_fire_d;
    out_tick_q   <= out_tick_d;
    out_wait_q   <= out_wait_d;
  end

  assign in_stall_o  = (state_q != SEQ_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign fire_o      = out_fire_q;
  assign fire_tick_o = out_tick_q;
  assign wait_ns_o   = out_wait_q;

`ifndef SYNTHESIS
  a_md_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_done |-> (state_q == SEQ_MUL || state_q == SEQ_DIV))
    else $error("muldiv done outside a wait state");

  a_suspended_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_DONE && !running_q) |-> (res_wait_q == 64'd0))
    else $error("nonzero wait while suspended");

  a_fire_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fire_o) |-> (status_o == ST_OK))
    else $error("firing word with error status");

  a_sample_fire_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_DONE && res_fire_q) |-> (act_q == ACT_SAMPLE))
    else $error("fire on a non-sample command");
`endif

endmodule

`default_nettype wire

[design/ptmr_muldiv.sv]
// ----------------------------------------------------------------------------
// Iterative multiply / divide unit
// One shared 66-bit adder, one bit per cycle: shift-add multiply (low word)
// or restoring divide (quotient).
// ----------------------------------------------------------------------------
`default_nettype none

module ptmr_muldiv (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ptmr_pkg::md_req_t     req_i,
  input  wire logic [63:0]           a_i,
  input  wire logic [63:0]           b_i,
  output logic                       done_o,
  output logic [63:0]                result_o
);
  import ptmr_pkg::*;

  localparam int unsigned CntW = $clog2(TimeW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  md_op_e          op_q, op_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [63:0]     acc_q, acc_d;
  logic [63:0]     a_q, a_d;
  logic [63:0]     b_q, b_d;
  logic [65:0]     op_x, op_y, sum;
  logic            cin;

  // mul: acc + a ; div: {acc, msb of dividend} - divisor
  always_comb begin
    if (op_q == MD_MUL) begin
      op_x = {2'b00, acc_q};
      op_y = {2'b00, a_q};
      cin  = 1'b0;
    end else begin
      op_x = {1'b0, acc_q, b_q[63]};
      op_y = ~{2'b00, a_q};
      cin  = 1'b1;
    end
    sum = op_x + op_y + {65'd0, cin};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      cnt_d  = '0;
      acc_d  = '0;
      if (req_i.op == MD_MUL) begin
        a_d = a_i;
        b_d = b_i;
      end else begin
        a_d = b_i;
        b_d = a_i;
      end
    end else if (busy_q) begin
      cnt_d = cnt_q + CntW'(1);
      if (op_q == MD_MUL) begin
        if (b_q[0]) begin
          acc_d = sum[63:0];
        end
        a_d = {a_q[62:0], 1'b0};
        b_d = {1'b0, b_q[63:1]};
      end else begin
        if (!sum[65]) begin
          acc_d = sum[63:0];
        end else begin
          acc_d = op_x[63:0];
        end
        b_d = {b_q[62:0], ~sum[65]};
      end
      if (cnt_q == CntW'(TimeW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= MD_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign done_o   = done_q;
  assign result_o = (op_q == MD_MUL) ? acc_q : b_q;

endmodule

`default_nettype wire

[dv/periodic_timer_with_catchup_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Periodic timer with catch-up: testbench
// Drives start/stop/interval/sample words with random gaps and output stalls.
// It predicts every result from a local timer model and checks each field.
// Directed words cover the edge cases, and random phases revisit the
// configuration registers, including their extremes.
// ----------------------------------------------------------------------------
module periodic_timer_with_catchup_core_tb;
  import ptmr_pkg::*;

  localparam int unsigned CatchupLimit = 60;
  localparam int ItemGoal = 1950;
  localparam logic [63:0] DefMin = 64'd100_000_000;
  localparam logic [31:0] DefRetry = 32'd1_000_000;

  typedef struct {
    action_e     action;
    logic [63:0] now_ns;
    logic [63:0] first_delay;
    logic [63:0] new_interval;
  } cmd_t;

  typedef struct {
    status_e     status;
    logic        fire;
    logic [63:0] fire_tick;
    logic [63:0] wait_ns;
  } res_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  cfg_idx_e    cfg_idx = CFG_MIN_INTERVAL;
  logic [63:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  action_e     action = ACT_START;
  logic [63:0] now_ns = '0;
  logic [63:0] first_delay = '0;
  logic [63:0] new_interval = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic        fire;
  logic [63:0] fire_tick;
  logic [63:0] wait_ns;

  // timer model state and register copies
  logic        tm_running = 1'b0;
  logic [63:0] tm_start = '0;
  logic [63:0] tm_next = '0;
  logic [63:0] tm_tick = '0;
  logic [63:0] tm_period = '0;
  logic [63:0] cfg_min = DefMin;
  logic [31:0] cfg_retry = DefRetry;

  cmd_t cmd_q[$];
  res_t result_q[$];
  cmd_t cur_cmd;
  bit   in_hold = 1'b0;
  bit   in_taken = 1'b0;
  bit   out_taken = 1'b0;
  int   in_gap = 0;
  int   stall_left = 0;
  int   gap_max = 14;
  int   stall_max = 14;
  int   n_sent = 0;
  int   errors = 0;
  logic [63:0] gen_now = '0;

  periodic_timer_with_catchup_core #(
    .CATCHUP_LIMIT(CatchupLimit)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .action_i      (action),
    .now_ns_i      (now_ns),
    .first_delay_i (first_delay),
    .new_interval_i(new_interval),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .fire_o        (fire),
    .fire_tick_o   (fire_tick),
    .wait_ns_o     (wait_ns)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(64'd30_000_000);
    $display("simulation failed");
    $finish;
  end

  // ---------------- timer model ----------------
  function automatic bit too_short(input logic [63:0] v);
    return v != 64'd0 && v < cfg_min;
  endfunction

  function automatic logic [63:0] wait_after(input logic [63:0] now);
    return (tm_running && tm_next > now) ? tm_next - now : 64'd0;
  endfunction

  task automatic arm_timer(input logic [63:0] at);
    tm_tick = '0;
    tm_start = at;
    tm_next = at;
    tm_running = 1'b1;
  endtask

  task automatic timer_step(input cmd_t c, output res_t r);
    logic [63:0] nxt;
    logic [63:0] behind;
    r.status = ST_OK;
    r.fire = 1'b0;
    r.fire_tick = '0;
    r.wait_ns = '0;
    case (c.action)
      ACT_START: begin
        if (too_short(c.first_delay)) r.status = ST_RANGE;
        else if (tm_running) r.status = ST_ACTIVE;
        else arm_timer(c.now_ns + c.first_delay);
        r.wait_ns = wait_after(c.now_ns);
      end
      ACT_STOP: begin
        if (!tm_running) r.status = ST_SUSPENDED;
        else tm_running = 1'b0;
      end
      ACT_IVAL: begin
        if (too_short(c.new_interval)) begin
          r.status = ST_RANGE;
        end else begin
          tm_period = c.new_interval;
          if (tm_running) arm_timer(c.now_ns);
        end
        r.wait_ns = wait_after(c.now_ns);
      end
      default: begin
        if (tm_running && c.now_ns >= tm_next) begin
          tm_tick = tm_tick + 64'd1;
          r.fire = 1'b1;
          r.fire_tick = tm_tick;
          if (tm_period == 64'd0) begin
            tm_running = 1'b0;
          end else begin
            nxt = tm_start + tm_tick * tm_period;
            if (nxt > c.now_ns) begin
              r.wait_ns = nxt - c.now_ns;
            end else begin
              behind = (c.now_ns - tm_start) / tm_period;
              if (behind - tm_tick > 64'(CatchupLimit)) tm_tick = behind - 64'd1;
              r.wait_ns = {32'd0, cfg_retry};
              nxt = c.now_ns + {32'd0, cfg_retry};
            end
            tm_next = nxt;
          end
        end else if (tm_running) begin
          r.wait_ns = tm_next - c.now_ns;
        end
      end
    endcase
  endtask

  // ---------------- driver ----------------
  always @(posedge clk) begin : drv_accept
    res_t r;
    if (rst_n && in_valid && !in_stall) begin
      timer_step(cur_cmd, r);
      result_q.push_back(r);
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        in_taken = 1'b0;
        in_hold = 1'b0;
        in_gap = $urandom_range(0, gap_max);
      end
      if (!in_hold) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          cur_cmd = cmd_q.pop_front();
          action <= cur_cmd.action;
          now_ns <= cur_cmd.now_ns;
          first_delay <= cur_cmd.first_delay;
          new_interval <= cur_cmd.new_interval;
          in_valid <= 1'b1;
          in_hold = 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin : mon_check
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      out_taken = 1'b1;
      if (result_q.size() == 0) begin
        $error("unexpected result word: status %0d fire %0d", status, fire);
        errors++;
      end else begin
        want = result_q.pop_front();
        if (status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          errors++;
        end
        if (fire != want.fire) begin
          $error("fire: expected %0d, got %0d", want.fire, fire);
          errors++;
        end
        if (fire_tick != want.fire_tick) begin
          $error("fire_tick: expected %0d, got %0d", want.fire_tick, fire_tick);
          errors++;
        end
        if (wait_ns != want.wait_ns) begin
          $error("wait_ns: expected %0d, got %0d", want.wait_ns, wait_ns);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        out_taken = 1'b0;
        stall_left = $urandom_range(0, stall_max);
      end
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // ---------------- stimulus ----------------
  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic push_cmd(input action_e a, input logic [63:0] now,
                          input logic [63:0] fd, input logic [63:0] ival);
    cmd_t c;
    c.action = a;
    c.now_ns = now;
    c.first_delay = fd;
    c.new_interval = ival;
    cmd_q.push_back(c);
    n_sent++;
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MIN_INTERVAL) cfg_min = val;
    else cfg_retry = val[31:0];
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (cmd_q.size() != 0 || in_hold || result_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // zero, just below minimum, at minimum, random, or a bit above
  function automatic logic [63:0] pick_period();
    logic [63:0] lo;
    lo = (cfg_min == 64'd0) ? 64'd1 : cfg_min;
    case ($urandom_range(0, 11))
      0: return 64'd0;
      1: return (lo > 64'd1) ? lo - 64'd1 : 64'd0;
      2: return lo;
      3: return rand64();
      default: return (lo > 64'hFFFF_FFFF_FFFF_0000) ? lo : lo + $urandom_range(0, 5000);
    endcase
  endfunction

  function automatic logic [63:0] pick_step(input logic [63:0] p);
    logic [63:0] u;
    u = (p == 64'd0) ? 64'd1000 : p;
    case ($urandom_range(0, 11))
      0, 1: return {32'd0, $urandom} % u;
      2, 3, 4, 5: return u;
      6: return u * $urandom_range(2, 59);
      7: return u * $urandom_range(61, 400) + {32'd0, $urandom} % u;
      8: return {32'd0, cfg_retry};
      9: return 64'd0;
      10: return rand64();
      default: return u + 64'd1;
    endcase
  endfunction

  task automatic run_episode();
    logic [63:0] p;
    logic [63:0] t;
    int n;
    case ($urandom_range(0, 3))
      0: t = rand64();
      1: t = 64'd0 - {32'd0, $urandom_range(1, 1 << 30)};
      default: t = gen_now;
    endcase
    p = pick_period();
    push_cmd(ACT_IVAL, t, rand64(), p);
    push_cmd(ACT_START, t, pick_period(), rand64());
    n = $urandom_range(3, 14);
    repeat (n) begin
      case ($urandom_range(0, 15))
        0: begin
          p = pick_period();
          push_cmd(ACT_IVAL, t, rand64(), p);
        end
        1: push_cmd(ACT_START, t, pick_period(), rand64());
        2: push_cmd(ACT_STOP, t, rand64(), rand64());
        default: begin
          t = t + pick_step(p);
          push_cmd(ACT_SAMPLE, t, rand64(), rand64());
        end
      endcase
    end
    push_cmd(ACT_STOP, t, rand64(), rand64());
    if ($urandom_range(0, 3) == 0) push_cmd(ACT_STOP, t, rand64(), rand64());
    gen_now = t;
  endtask

  initial begin : stimulus
    logic [63:0] t0;
    logic [63:0] new_min;
    logic [31:0] new_retry;
    int phase;
    int phase_end;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed words, reset configuration
    push_cmd(ACT_STOP, 64'd0, rand64(), rand64());
    push_cmd(ACT_SAMPLE, '1, '1, '1);
    push_cmd(ACT_START, 64'd10, 64'd1, '0);
    push_cmd(ACT_IVAL, 64'd10, '0, DefMin - 64'd1);
    push_cmd(ACT_IVAL, 64'd10, '1, 64'd0);
    push_cmd(ACT_START, 64'd5, 64'd0, '1);
    push_cmd(ACT_START, 64'd6, DefMin, '0);
    push_cmd(ACT_SAMPLE, 64'd5, '0, '0);
    push_cmd(ACT_SAMPLE, 64'd6, '0, '0);
    push_cmd(ACT_IVAL, 64'd7, '0, DefMin);
    // fire time wraps past 2^64
    push_cmd(ACT_START, 64'd0 - 64'd50_000_000, DefMin, '0);
    push_cmd(ACT_SAMPLE, '1, '0, '0);
    push_cmd(ACT_SAMPLE, 64'd999_999, '0, '0);
    push_cmd(ACT_STOP, 64'd1000, '0, '0);
    push_cmd(ACT_START, 64'd1000, 64'd0, '0);
    push_cmd(ACT_IVAL, 64'd2000, '0, '1);
    push_cmd(ACT_SAMPLE, 64'd2000, '0, '0);
    // far behind schedule: tick jumps ahead
    t0 = 64'd1_000_000_000;
    push_cmd(ACT_IVAL, t0, '0, DefMin);
    push_cmd(ACT_SAMPLE, t0 + 64'd100 * DefMin, '0, '0);
    push_cmd(ACT_SAMPLE, t0 + 64'd100 * DefMin, '0, '0);
    push_cmd(ACT_SAMPLE, t0 + 64'd100 * DefMin + DefRetry, '0, '0);
    push_cmd(ACT_STOP, t0, '0, '0);
    push_cmd(ACT_STOP, t0, '0, '0);
    push_cmd(ACT_START, 64'd123, '1, '0);
    push_cmd(ACT_SAMPLE, 64'd124, '0, '0);
    wait_idle();

    phase = 0;
    while (n_sent < ItemGoal) begin
      case (phase)
        0: begin new_min = 64'd0; new_retry = 32'd0; end
        1: begin new_min = 64'd1; new_retry = 32'hFFFF_FFFF; end
        2: begin new_min = '1; new_retry = 32'd1; end
        3: begin new_min = DefMin; new_retry = DefRetry; end
        default: begin
          new_min = ($urandom_range(0, 7) == 0) ? rand64() : {32'd0, $urandom_range(0, 5000)};
          new_retry = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20000);
        end
      endcase
      if ($urandom_range(0, 1) == 0) begin
        cfg_write(CFG_MIN_INTERVAL, new_min);
        cfg_write(CFG_LATE_RETRY, {$urandom, new_retry});
      end else begin
        cfg_write(CFG_LATE_RETRY, {$urandom, new_retry});
        cfg_write(CFG_MIN_INTERVAL, new_min);
      end
      case ($urandom_range(0, 3))
        0: gap_max = 0;
        1: gap_max = $urandom_range(1, 14);
        default: gap_max = 14;
      endcase
      case ($urandom_range(0, 3))
        0: stall_max = 0;
        1: stall_max = $urandom_range(1, 14);
        default: stall_max = 14;
      endcase
      phase_end = n_sent + $urandom_range(50, 110);
      while (n_sent < phase_end) begin
        if ($urandom_range(0, 9) < 8) begin
          run_episode();
        end else begin
          repeat ($urandom_range(1, 3))
            push_cmd(action_e'(2'($urandom_range(0, 3))), rand64(), rand64(), rand64());
        end
      end
      wait_idle();
      phase++;
    end

    repeat (150) @(posedge clk);
    if (errors == 0 && result_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
design/ptmr_pkg.sv
design/ptmr_muldiv.sv
design/periodic_timer_with_catchup_core.sv
dv/periodic_timer_with_catchup_core_tb.sv
